// ===== rtl/pdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared constants, widths and tables for the point projection depth raster.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdr_pkg;

    localparam int SCREEN_WIDTH  = 90;
    localparam int SCREEN_HEIGHT = 45;
    localparam int H_COMPRESS    = 1;
    localparam int V_COMPRESS    = 2;

    localparam int PIX_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W    = $clog2(PIX_DEPTH);

    localparam int COL_DIV = 256 * H_COMPRESS;
    localparam int ROW_DIV = 256 * V_COMPRESS;

    localparam int CORDIC_STEPS = 14;
    localparam int CRD_W        = 30;   // CORDIC vector width
    localparam int ANG_W        = 18;   // Q8 degrees, signed

    localparam logic [3:0] EMPTY_LEVEL = 4'd8;
    localparam int         LEVEL_THRESHOLDS = 6;

    localparam logic signed [ANG_W-1:0] ANG_90 = 18'sd23040;

    // configuration register indexes
    localparam logic [1:0] REG_CAM_X = 2'd0;
    localparam logic [1:0] REG_CAM_Y = 2'd1;
    localparam logic [1:0] REG_CAM_Z = 2'd2;
    localparam logic [1:0] REG_RDIST = 2'd3;

    function automatic logic [ANG_W-1:0] atan_q8(input logic [3:0] i);
        logic [ANG_W-1:0] t;
        case (i)
            4'd0:  t = 18'd11520;
            4'd1:  t = 18'd6801;
            4'd2:  t = 18'd3593;
            4'd3:  t = 18'd1824;
            4'd4:  t = 18'd916;
            4'd5:  t = 18'd458;
            4'd6:  t = 18'd229;
            4'd7:  t = 18'd115;
            4'd8:  t = 18'd57;
            4'd9:  t = 18'd29;
            4'd10: t = 18'd14;
            4'd11: t = 18'd7;
            4'd12: t = 18'd4;
            4'd13: t = 18'd2;
            default: t = 18'd0;
        endcase
        return t;
    endfunction

    // percentage bounds between depth levels
    function automatic logic [6:0] level_bound(input logic [2:0] i);
        logic [6:0] b;
        case (i)
            3'd0: b = 7'd14;
            3'd1: b = 7'd28;
            3'd2: b = 7'd42;
            3'd3: b = 7'd56;
            3'd4: b = 7'd70;
            3'd5: b = 7'd84;
            default: b = 7'd100;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/pdr_ram.sv =====
// ----------------------------------------------------------------------------
// pdr_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pdr_cordic.sv =====
// ----------------------------------------------------------------------------
// pdr_cordic
// Vectoring CORDIC, one micro-rotation per cycle, returns atan2 in Q8 degrees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdr_cordic
    import pdr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [CRD_W-1:0] x_in,
    input  logic signed [CRD_W-1:0] y_in,
    output logic                    done,
    output logic signed [ANG_W-1:0] ang
);

    logic signed [CRD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0] ang_reg, ang_next;
    logic [3:0]              i_reg, i_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic signed [CRD_W-1:0] xs, ys;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        ang_next  = ang_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        if (start) begin
            busy_next = 1'b1;
            i_next    = 4'd0;
            if (x_in < 0) begin
                // turn into the right half plane first
                if (y_in >= 0) begin
                    x_next   = y_in;
                    y_next   = -x_in;
                    ang_next = ANG_90;
                end else begin
                    x_next   = -y_in;
                    y_next   = x_in;
                    ang_next = -ANG_90;
                end
            end else begin
                x_next   = x_in;
                y_next   = y_in;
                ang_next = '0;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next   = x_reg + ys;
                y_next   = y_reg - xs;
                ang_next = ang_reg + $signed(atan_q8(i_reg));
            end else if (y_reg < 0) begin
                x_next   = x_reg - ys;
                y_next   = y_reg + xs;
                ang_next = ang_reg - $signed(atan_q8(i_reg));
            end
            i_next = i_reg + 4'd1;
            if (i_reg == 4'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign done = done_reg;
    assign ang  = ang_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && i_reg == 4'd0)
        else $error("cordic start not taken");
    a_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !busy_reg)
        else $error("cordic done while busy");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("cordic restarted while busy");

endmodule

// ===== rtl/point_project_depth_raster.sv =====
// ----------------------------------------------------------------------------
// point_project_depth_raster
// Projects points to a small depth raster through shared CORDIC, square root
// and compare units; read beats return and empty a pixel.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: kind; tdata: x, y, z, col, row
// m_        out  m_tvalid/m_tready  tdata: on_screen, col, row, level, updated
// cfg_      in   cfg_wen            cfg_index, cfg_wdata
//
// Plot beat: three squares, two 19-step square roots, two CORDIC passes, six
// level compares, raster read and write; a new beat is taken only once the last
// one has reached the result register. An off screen plot stops after the angles.
// Read beat: range check, then the raster read-modify-write to the result.
// After reset a clearing pass writes all PIX_DEPTH (4050) pixels with
// s_tready low. A held result does not stop the next beat from entering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_project_depth_raster
    import pdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // point_x, point_y, point_z, read_col, read_row
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // on_screen, pixel_col, pixel_row, level, updated
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SUB   = 4'd2;
    localparam logic [3:0] ST_SQ    = 4'd3;
    localparam logic [3:0] ST_SQRTP = 4'd4;
    localparam logic [3:0] ST_CORDH = 4'd5;
    localparam logic [3:0] ST_CORDV = 4'd6;
    localparam logic [3:0] ST_CHECK = 4'd7;
    localparam logic [3:0] ST_SQRTD = 4'd8;
    localparam logic [3:0] ST_NUM   = 4'd9;
    localparam logic [3:0] ST_LEVEL = 4'd10;
    localparam logic [3:0] ST_RAMRD = 4'd11;
    localparam logic [3:0] ST_WB    = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;
    localparam logic [3:0] ST_RDCHK = 4'd14;

    localparam int SQ_IN_W = 38;
    localparam logic [4:0] SQ_TOP = 5'd18;

    // configuration
    logic signed [9:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [9:0]        rdist_reg;

    logic [3:0] state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    logic              kind_reg, kind_next;
    logic signed [9:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [6:0]        rc_reg, rc_next;
    logic [5:0]        rr_reg, rr_next;

    logic signed [10:0] dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [21:0]        acc_reg, acc_next, pl2_reg, pl2_next;

    logic [SQ_IN_W-1:0] sqn_reg, sqn_next, sqr_reg, sqr_next, sq_t;
    logic [4:0]         sqk_reg, sqk_next;
    logic [19:0]        r_reg, r_next;

    logic signed [ANG_W-1:0] ah_reg, ah_next, av_reg, av_next;
    logic [26:0]             num_reg, num_next;
    logic [2:0]              li_reg, li_next;
    logic [3:0]              lvl_reg, lvl_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;

    logic       res_on_reg, res_on_next, res_upd_reg, res_upd_next;
    logic [6:0] res_col_reg, res_col_next;
    logic [5:0] res_row_reg, res_row_next;
    logic [3:0] res_lvl_reg, res_lvl_next;

    logic        m_valid_reg, m_valid_next;
    logic [18:0] m_data_reg, m_data_next;

    // shared units
    logic signed [10:0] mul_op;
    logic [21:0]        mul_p;
    logic               crd_start, crd_done;
    logic signed [CRD_W-1:0] crd_x, crd_y;
    logic signed [ANG_W-1:0] crd_ang;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [3:0]          ram_wdata, ram_rdata;

    logic [9:0]        rd_eff;
    logic [ANG_W-2:0]  ah_mag, av_mag;
    logic [ANG_W-1:0]  col_q, row_q;
    logic              col_bad, row_bad;
    logic [24:0]       bound_val;

    assign rd_eff = (rdist_reg == 10'd0) ? 10'd1 : rdist_reg;
    assign sq_t   = sqr_reg + (SQ_IN_W'(1) << {sqk_reg, 1'b0});

    always_comb begin
        case (cnt_reg)
            2'd0:    mul_op = dx_reg;
            2'd1:    mul_op = dz_reg;
            default: mul_op = dy_reg;
        endcase
    end
    assign mul_p = 22'(mul_op * mul_op);

    // rounding of angles to pixels, half away from zero
    assign ah_mag  = ah_reg[ANG_W-1] ? (ANG_W-1)'(-ah_reg) : ah_reg[ANG_W-2:0];
    assign av_mag  = av_reg[ANG_W-1] ? (ANG_W-1)'(-av_reg) : av_reg[ANG_W-2:0];
    assign col_q   = ANG_W'(({1'b0, ah_mag} + ANG_W'(COL_DIV / 2)) / COL_DIV);
    assign row_q   = ANG_W'(({1'b0, av_mag} + ANG_W'(ROW_DIV / 2)) / ROW_DIV);
    assign col_bad = (ah_reg[ANG_W-1] && col_q != '0) || col_q >= ANG_W'(SCREEN_WIDTH);
    assign row_bad = (av_reg[ANG_W-1] && row_q != '0) || row_q >= ANG_W'(SCREEN_HEIGHT);

    assign bound_val = {17'(level_bound(li_reg)) * 17'(rd_eff), 8'd0};

    assign crd_x = (state_reg == ST_SQRTP) ? {{3{dx_reg[10]}}, dx_reg, 16'd0}
                                           : CRD_W'({2'b00, r_reg, 8'd0});
    assign crd_y = (state_reg == ST_SQRTP) ? {{3{dz_reg[10]}}, dz_reg, 16'd0}
                                           : {{3{dy_reg[10]}}, dy_reg, 16'd0};

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        kind_next    = kind_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        rc_next      = rc_reg;
        rr_next      = rr_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dz_next      = dz_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        pl2_next     = pl2_reg;
        sqn_next     = sqn_reg;
        sqr_next     = sqr_reg;
        sqk_next     = sqk_reg;
        r_next       = r_reg;
        ah_next      = ah_reg;
        av_next      = av_reg;
        num_next     = num_reg;
        li_next      = li_reg;
        lvl_next     = lvl_reg;
        addr_next    = addr_reg;
        res_on_next  = res_on_reg;
        res_upd_next = res_upd_reg;
        res_col_next = res_col_reg;
        res_row_next = res_row_reg;
        res_lvl_next = res_lvl_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        crd_start    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = EMPTY_LEVEL;
        s_tready     = (state_reg == ST_IDLE);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // one root bit per cycle, shared by both distances
        if (state_reg == ST_SQRTP || state_reg == ST_SQRTD) begin
            if (sqn_reg >= sq_t) begin
                sqn_next = sqn_reg - sq_t;
                sqr_next = (sqr_reg >> 1) + (SQ_IN_W'(1) << {sqk_reg, 1'b0});
            end else begin
                sqr_next = sqr_reg >> 1;
            end
            sqk_next = sqk_reg - 5'd1;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(PIX_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next    = s_tuser;
                    px_next      = s_tdata[9:0];
                    py_next      = s_tdata[19:10];
                    pz_next      = s_tdata[29:20];
                    rc_next      = s_tdata[36:30];
                    rr_next      = s_tdata[42:37];
                    res_on_next  = 1'b0;
                    res_upd_next = 1'b0;
                    res_col_next = '0;
                    res_row_next = '0;
                    res_lvl_next = EMPTY_LEVEL;
                    state_next   = s_tuser ? ST_RDCHK : ST_SUB;
                end
            end
            ST_SUB: begin
                dx_next    = 11'(px_reg) - 11'(cam_x_reg);
                dy_next    = 11'(py_reg) - 11'(cam_y_reg);
                dz_next    = 11'(pz_reg) - 11'(cam_z_reg);
                cnt_next   = 2'd0;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cnt_next = cnt_reg + 2'd1;
                case (cnt_reg)
                    2'd0: acc_next = mul_p;
                    2'd1: begin
                        acc_next = acc_reg + mul_p;
                        pl2_next = acc_reg + mul_p;
                    end
                    default: begin
                        acc_next   = acc_reg + mul_p;
                        sqn_next   = {pl2_reg, 16'd0};
                        sqr_next   = '0;
                        sqk_next   = SQ_TOP;
                        state_next = ST_SQRTP;
                    end
                endcase
            end
            ST_SQRTP: begin
                if (sqk_reg == 5'd0) begin
                    r_next     = 20'(sqr_next);
                    state_next = ST_CORDH;
                end
            end
            ST_CORDH: begin
                // column angle lands, row pass starts on the planar root
                if (crd_done) begin
                    ah_next    = crd_ang;
                    crd_start  = 1'b1;
                    state_next = ST_CORDV;
                end
            end
            ST_CORDV: begin
                if (crd_done) begin
                    av_next    = crd_ang;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (col_bad || row_bad) begin
                    state_next = ST_DONE;
                end else begin
                    res_col_next = col_q[6:0];
                    res_row_next = row_q[5:0];
                    addr_next    = ADDR_W'(row_q[5:0] * SCREEN_WIDTH) + ADDR_W'(col_q[6:0]);
                    sqn_next     = {acc_reg, 16'd0};
                    sqr_next     = '0;
                    sqk_next     = SQ_TOP;
                    state_next   = ST_SQRTD;
                end
            end
            ST_SQRTD: begin
                if (sqk_reg == 5'd0) begin
                    r_next     = 20'(sqr_next);
                    state_next = ST_NUM;
                end
            end
            ST_NUM: begin
                num_next   = 27'(r_reg) * 27'd100 + 27'({rd_eff, 7'd0});
                li_next    = 3'd0;
                lvl_next   = 4'd1;
                state_next = ST_LEVEL;
            end
            ST_LEVEL: begin
                if (num_reg >= 27'(bound_val)) begin
                    lvl_next = lvl_reg + 4'd1;
                end
                li_next = li_reg + 3'd1;
                if (li_reg == 3'(LEVEL_THRESHOLDS - 1)) begin
                    state_next = ST_RAMRD;
                end
            end
            ST_RAMRD: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                res_on_next = 1'b1;
                if (kind_reg) begin
                    res_lvl_next = ram_rdata;
                    ram_we       = 1'b1;
                end else begin
                    res_lvl_next = lvl_reg;
                    if (lvl_reg < ram_rdata) begin
                        ram_we       = 1'b1;
                        ram_wdata    = lvl_reg;
                        res_upd_next = 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_RDCHK: begin
                if (rc_reg < 7'(SCREEN_WIDTH) && rr_reg < 6'(SCREEN_HEIGHT)) begin
                    res_col_next = rc_reg;
                    res_row_next = rr_reg;
                    addr_next    = ADDR_W'(rr_reg * SCREEN_WIDTH) + ADDR_W'(rc_reg);
                    state_next   = ST_RAMRD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_upd_reg, res_lvl_reg, res_row_reg,
                                    res_col_reg, res_on_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // column pass starts in the last cycle of the planar root
        if (state_reg == ST_SQRTP && sqk_reg == 5'd0) begin
            crd_start = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            sqk_reg     <= '0;
            li_reg      <= '0;
            cam_x_reg   <= -10'sd10;
            cam_y_reg   <= -10'sd10;
            cam_z_reg   <= -10'sd10;
            rdist_reg   <= 10'd50;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            sqk_reg     <= sqk_next;
            li_reg      <= li_next;
            if (cfg_wen) begin
                case (cfg_index)
                    REG_CAM_X: cam_x_reg <= cfg_wdata;
                    REG_CAM_Y: cam_y_reg <= cfg_wdata;
                    REG_CAM_Z: cam_z_reg <= cfg_wdata;
                    REG_RDIST: rdist_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        kind_reg    <= kind_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pz_reg      <= pz_next;
        rc_reg      <= rc_next;
        rr_reg      <= rr_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dz_reg      <= dz_next;
        acc_reg     <= acc_next;
        pl2_reg     <= pl2_next;
        sqn_reg     <= sqn_next;
        sqr_reg     <= sqr_next;
        r_reg       <= r_next;
        ah_reg      <= ah_next;
        av_reg      <= av_next;
        num_reg     <= num_next;
        lvl_reg     <= lvl_next;
        addr_reg    <= addr_next;
        res_on_reg  <= res_on_next;
        res_upd_reg <= res_upd_next;
        res_col_reg <= res_col_next;
        res_row_reg <= res_row_next;
        res_lvl_reg <= res_lvl_next;
        m_data_reg  <= m_data_next;
    end

    pdr_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (crd_start),
        .x_in    (crd_x),
        .y_in    (crd_y),
        .done    (crd_done),
        .ang     (crd_ang)
    );

    pdr_ram #(
        .WIDTH (4),
        .DEPTH (PIX_DEPTH)
    ) u_raster (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> ram_we && ram_wdata == EMPTY_LEVEL)
        else $error("clearing pass wrote a non-empty level");
    a_off_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg[0] |-> m_data_reg[17:14] == EMPTY_LEVEL
                                          && !m_data_reg[18])
        else $error("off screen result carries a level");
    a_upd_closer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[18] |-> m_data_reg[17:14] < EMPTY_LEVEL
                                          && m_data_reg[0])
        else $error("update flagged without a depth level");

endmodule
